// ----- sv/tcw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, character codes, command codes and display memory port
// types shared by the console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS       = 80;
	localparam int ROWS          = 25;
	localparam int CELL_COUNT    = ROWS * COLUMNS;
	localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W        = $clog2(CELL_COUNT);
	localparam int ROW_W         = $clog2(ROWS);
	localparam int COL_W         = $clog2(COLUMNS);
	localparam int CELL_W        = 16;
	localparam int CURSOR_W      = 11;

	localparam logic [7:0]        CH_NEWLINE  = 8'h0A;
	localparam logic [7:0]        CH_RETURN   = 8'h0D;
	localparam logic [7:0]        CH_SPACE    = 8'h20;
	localparam logic [7:0]        COLOR_RESET = 8'h07;
	localparam logic [CELL_W-1:0] RESET_CELL  = 16'h0720;

	typedef enum logic [1:0] {
		CMD_PUT  = 2'd0,
		CMD_SET  = 2'd1,
		CMD_READ = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

endpackage
`default_nettype wire

// ----- sv/tcw_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Display memory
// One write port and one read port with registered read data, holding the
// character and attribute cells of the screen.
// ----------------------------------------------------------------------------
module tcw_ram (
	input  wire logic                        clk,
	input  wire tcw_pkg::ram_wr_t            wr,
	input  wire tcw_pkg::ram_rd_t            rd,
	output logic [tcw_pkg::CELL_W-1:0]       rd_data
);

	logic [tcw_pkg::CELL_W-1:0] mem_q [tcw_pkg::CELL_COUNT];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem_q[rd.addr];
		end
	end

endmodule
`default_nettype wire

// ----- sv/tcw_addr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Cell address unit
// Shared row/column to linear cell index: row * COLUMNS + column.
// ----------------------------------------------------------------------------
module tcw_addr (
	input  wire logic [tcw_pkg::ROW_W-1:0]  row,
	input  wire logic [tcw_pkg::COL_W-1:0]  col,
	output logic [tcw_pkg::ADDR_W-1:0]      lin
);

	localparam int AW = tcw_pkg::ADDR_W;

	assign lin = AW'(int'(row) * tcw_pkg::COLUMNS) + AW'(col);

endmodule
`default_nettype wire

// ----- sv/text_console_writer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode console engine over a ROWS x COLUMNS screen of 16-bit cells
// (character low byte, attribute high byte). One transaction on the input
// channel gives one transaction on the output channel. After reset the block
// clears the display memory to blank cells, one cell a cycle, before the
// first input is taken; colour writes are taken at any time. Put character,
// set position and the unused command pass through the execute state only;
// read cell adds a state that captures the registered read data. A put that
// scrolls first copies each row up by one through the memory read and write
// ports, then fills the last row with blank cells in the current colour.
// A finished result waits in the output register while the next item is
// accepted.
// ----------------------------------------------------------------------------
module text_console_writer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  char_code,
	input  wire logic [4:0]  row_sel,
	input  wire logic [6:0]  col_sel,
	input  wire logic        update_cursor,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [10:0]      cursor_pos,
	output logic [15:0]      cell_data,
	output logic             scrolled,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	localparam int AW   = tcw_pkg::ADDR_W;
	localparam int RW   = tcw_pkg::ROW_W;
	localparam int CW   = tcw_pkg::COL_W;
	localparam int CURW = tcw_pkg::CURSOR_W;
	localparam int DW   = tcw_pkg::CELL_W;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_READ,
		S_COPY,
		S_FILL,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     idx_q;
	logic              cp_wr_s1;
	logic [AW-1:0]     cp_addr_s1;
	tcw_pkg::cmd_t     cmd_q;
	logic [7:0]        char_q;
	logic [RW-1:0]     rsel_q;
	logic [CW-1:0]     csel_q;
	logic              upd_q;
	logic [RW-1:0]     write_row_q;
	logic [CW-1:0]     write_col_q;
	logic [CURW-1:0]   shown_q;
	logic [7:0]        color_q;
	logic [DW-1:0]     res_cell_q;
	logic              res_scroll_q;
	logic              out_valid_q;
	logic [CURW-1:0]   cursor_pos_q;
	logic [DW-1:0]     cell_data_q;
	logic              scrolled_q;

	logic              in_fire;
	logic              out_free;
	logic              done_fire;
	logic              is_print;
	logic              row_adv;
	logic              at_last_row;
	logic              at_last_col;
	logic              cur_load;
	logic [RW-1:0]     row_clamp;
	logic [CW-1:0]     col_clamp;
	logic [RW-1:0]     addr_row;
	logic [CW-1:0]     addr_col;
	logic [AW-1:0]     lin;
	logic [CURW-1:0]   cur_new;
	logic [DW-1:0]     ram_rd_data;
	tcw_pkg::ram_wr_t  ram_wr;
	tcw_pkg::ram_rd_t  ram_rd;

	assign out_free    = !out_valid_q || out_ready;
	assign done_fire   = (state_q == S_DONE) && out_free;
	assign in_ready    = (state_q == S_IDLE) || done_fire;
	assign in_fire     = in_valid && in_ready;
	assign cfg_ready   = 1'b1;

	assign is_print    = (cmd_q == tcw_pkg::CMD_PUT) && (char_q != tcw_pkg::CH_NEWLINE)
	                     && (char_q != tcw_pkg::CH_RETURN);
	assign at_last_row = write_row_q == RW'(tcw_pkg::ROWS - 1);
	assign at_last_col = write_col_q == CW'(tcw_pkg::COLUMNS - 1);
	assign row_adv     = (char_q == tcw_pkg::CH_NEWLINE) || (is_print && at_last_col);
	assign cur_load    = upd_q || (cmd_q == tcw_pkg::CMD_SET);

	assign row_clamp = (int'(row_sel) > tcw_pkg::ROWS - 1) ? RW'(tcw_pkg::ROWS - 1)
	                                                       : RW'(row_sel);
	assign col_clamp = (int'(col_sel) > tcw_pkg::COLUMNS - 1) ? CW'(tcw_pkg::COLUMNS - 1)
	                                                          : CW'(col_sel);

	// read cell addresses the selected cell, everything else the write position
	always_comb begin
		if (state_q == S_EXEC && cmd_q == tcw_pkg::CMD_READ) begin
			addr_row = rsel_q;
			addr_col = csel_q;
		end else begin
			addr_row = write_row_q;
			addr_col = write_col_q;
		end
	end

	tcw_addr u_addr (
		.row (addr_row),
		.col (addr_col),
		.lin (lin)
	);

	assign cur_new = CURW'(lin);

	always_comb begin
		ram_wr = '0;
		case (state_q)
			S_INIT: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = idx_q;
				ram_wr.data = tcw_pkg::RESET_CELL;
			end
			S_EXEC: begin
				ram_wr.en   = is_print;
				ram_wr.addr = lin;
				ram_wr.data = {color_q, char_q};
			end
			S_COPY, S_FILL: begin
				if (cp_wr_s1) begin
					ram_wr.en   = 1'b1;
					ram_wr.addr = cp_addr_s1;
					ram_wr.data = ram_rd_data;
				end else if (state_q == S_FILL) begin
					ram_wr.en   = 1'b1;
					ram_wr.addr = idx_q;
					ram_wr.data = {color_q, tcw_pkg::CH_SPACE};
				end
			end
			default: begin
				ram_wr = '0;
			end
		endcase
	end

	always_comb begin
		ram_rd.en   = (state_q == S_COPY) || (state_q == S_EXEC && cmd_q == tcw_pkg::CMD_READ);
		ram_rd.addr = (state_q == S_COPY) ? idx_q : lin;
	end

	tcw_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd      (ram_rd),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			idx_q       <= '0;
			cp_wr_s1    <= 1'b0;
			write_row_q <= '0;
			write_col_q <= '0;
			shown_q     <= '0;
			color_q     <= tcw_pkg::COLOR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				color_q <= cfg_data;
			end
			// row copy: read one row ahead, write the cell back in the next cycle
			cp_wr_s1   <= (state_q == S_COPY);
			cp_addr_s1 <= idx_q - AW'(tcw_pkg::COLUMNS);
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					if (idx_q == AW'(tcw_pkg::CELL_COUNT - 1)) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					state_q <= S_IDLE;
				end
				S_EXEC: begin
					res_cell_q   <= '0;
					res_scroll_q <= 1'b0;
					state_q      <= S_DONE;
					case (cmd_q)
						tcw_pkg::CMD_PUT: begin
							if (row_adv) begin
								write_col_q <= '0;
								if (at_last_row) begin
									res_scroll_q <= 1'b1;
									idx_q        <= AW'(tcw_pkg::COLUMNS);
									state_q      <= S_COPY;
								end else begin
									write_row_q <= write_row_q + 1'b1;
								end
							end else if (char_q == tcw_pkg::CH_RETURN) begin
								write_col_q <= '0;
							end else begin
								write_col_q <= write_col_q + 1'b1;
							end
						end
						tcw_pkg::CMD_SET: begin
							write_row_q <= rsel_q;
							write_col_q <= csel_q;
						end
						tcw_pkg::CMD_READ: begin
							state_q <= S_READ;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_READ: begin
					res_cell_q <= ram_rd_data;
					state_q    <= S_DONE;
				end
				S_COPY: begin
					if (idx_q == AW'(tcw_pkg::CELL_COUNT - 1)) begin
						idx_q   <= AW'(tcw_pkg::LAST_ROW_BASE);
						state_q <= S_FILL;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_FILL: begin
					if (!cp_wr_s1) begin
						if (idx_q == AW'(tcw_pkg::CELL_COUNT - 1)) begin
							state_q <= S_DONE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					state_q <= S_DONE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (done_fire) begin
				out_valid_q  <= 1'b1;
				cell_data_q  <= res_cell_q;
				scrolled_q   <= res_scroll_q;
				cursor_pos_q <= cur_load ? cur_new : shown_q;
				if (cur_load) begin
					shown_q <= cur_new;
				end
				state_q <= S_IDLE;
			end
			if (in_fire) begin
				cmd_q   <= tcw_pkg::cmd_t'(cmd);
				char_q  <= char_code;
				rsel_q  <= row_clamp;
				csel_q  <= col_clamp;
				upd_q   <= update_cursor;
				state_q <= S_EXEC;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_pos = cursor_pos_q;
	assign cell_data  = cell_data_q;
	assign scrolled   = scrolled_q;

`ifndef SYNTHESIS
	a_scroll_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire && res_scroll_q |-> at_last_row)
		else $error("scroll reported with write row not on last row");

	a_pos_hold_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY || state_q == S_FILL) |=>
		$stable(write_row_q) && $stable(write_col_q))
		else $error("write position moved during scroll");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		write_col_q <= CW'(tcw_pkg::COLUMNS - 1) && write_row_q <= RW'(tcw_pkg::ROWS - 1))
		else $error("write position off screen");
`endif

endmodule
`default_nettype wire
